/* rtl/core/keypad_code_lock_top_defines.svh */
// assertion helpers for the keypad code lock
`ifndef KEYPAD_CODE_LOCK_TOP_DEFINES_SVH
`define KEYPAD_CODE_LOCK_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KCL_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KCL_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kcl_pkg.sv */
package kcl_pkg;

    localparam int CODE_LENGTH = 6;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int KIND_W      = 1;
    localparam int STATUS_W    = 3;
    localparam int ECOUNT_W    = 3;
    localparam int MODE_W      = 2;

    localparam logic [DIGIT_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W-1:0] KEY_CONFIRM   = 4'd13;
    localparam logic [DIGIT_W-1:0] KEY_BACK      = 4'd14;
    localparam logic [DIGIT_W-1:0] KEY_DELETE    = 4'd15;

    localparam logic [KIND_W-1:0]  KIND_KEY      = 1'b0;
    localparam logic [KIND_W-1:0]  KIND_CHANGE   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN    = 3'd0,
        ST_UNLOCKED = 3'd1,
        ST_WRONG    = 3'd2,
        ST_OLD_OK   = 3'd3,
        ST_CHANGED  = 3'd4,
        ST_ABORTED  = 3'd5,
        ST_IGNORED  = 3'd6
    } status_t;

    // factory code digit for position pos: (pos + 1) mod 10, pos below 19
    function automatic logic [DIGIT_W-1:0] default_digit(input int pos);
        int v;
        v = pos + 1;
        if (v >= 10)
        begin
            v = v - 10;
        end
        return DIGIT_W'(v);
    endfunction

endpackage

/* rtl/core/keypad_code_lock_top.sv */
// channel | direction | handshake            | word
// --------+-----------+----------------------+----------------------------------
// input   | in        | in_valid, in_stall   | kind, key_code
// output  | out       | out_valid, out_stall | status, entered_count, lock_mode
//
// one word per cycle while out_stall is low; each word passes the input register, then the result register
// the lock state updates as a word moves from the input register into the
// result register, so the next word sees it with no bubble
// rst_n clears control state and loads the factory code 1,2,3,4,5,6
// in_stall rises only while both registers are full and out_stall is high

`include "keypad_code_lock_top_defines.svh"

module keypad_code_lock_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kcl_pkg::KIND_W-1:0]        kind,
    input  logic [kcl_pkg::DIGIT_W-1:0]       key_code,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kcl_pkg::STATUS_W-1:0]      status,
    output logic [kcl_pkg::ECOUNT_W-1:0]      entered_count,
    output logic [kcl_pkg::MODE_W-1:0]        lock_mode
);

    import kcl_pkg::*;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 2'd0,
        MODE_UNLOCK = 2'd1,
        MODE_OLD    = 2'd2,
        MODE_NEW    = 2'd3
    } mode_t;

    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic [KIND_W-1:0]        kind_reg;
    logic [DIGIT_W-1:0]       key_reg;

    mode_t                    mode_reg;
    mode_t                    mode_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [DIGIT_W-1:0]       entry_reg  [CODE_LENGTH];
    logic [DIGIT_W-1:0]       stored_reg [CODE_LENGTH];

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;

    logic                     in_accept;
    logic                     advance;
    logic                     is_digit;
    logic                     full;
    logic                     match;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic                     copy_en;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign is_digit  = (key_reg <= KEY_DIGIT_MAX);
    assign full      = (count_reg == CNT_W'(CODE_LENGTH));

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (entry_reg[i] != stored_reg[i])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        status_next = ST_IGNORED;
        wr_en       = 1'b0;
        wr_idx      = IDX_W'(count_reg);
        copy_en     = 1'b0;

        if (mode_reg == MODE_IDLE)
        begin
            priority if (kind_reg == KIND_CHANGE)
            begin
                mode_next   = MODE_OLD;
                count_next  = '0;
                status_next = ST_TAKEN;
            end
            else if (is_digit)
            begin
                wr_en       = 1'b1;
                wr_idx      = '0;
                count_next  = CNT_W'(1);
                mode_next   = MODE_UNLOCK;
                status_next = ST_TAKEN;
            end
            else
            begin
                status_next = ST_IGNORED;
            end
        end
        else if (kind_reg == KIND_KEY)
        begin
            unique if (is_digit)
            begin
                if (!full)
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_TAKEN;
                end
            end
            else if (key_reg == KEY_DELETE)
            begin
                if (count_reg != '0)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_TAKEN;
                end
            end
            else if (key_reg == KEY_BACK)
            begin
                mode_next   = MODE_IDLE;
                count_next  = '0;
                status_next = ST_ABORTED;
            end
            else if (key_reg == KEY_CONFIRM)
            begin
                if (full)
                begin
                    count_next = '0;
                    unique case (mode_reg)
                        MODE_UNLOCK:
                        begin
                            mode_next = MODE_IDLE;
                            if (match)
                            begin
                                status_next = ST_UNLOCKED;
                            end
                            else
                            begin
                                status_next = ST_WRONG;
                            end
                        end
                        MODE_OLD:
                        begin
                            if (match)
                            begin
                                status_next = ST_OLD_OK;
                                mode_next   = MODE_NEW;
                            end
                            else
                            begin
                                status_next = ST_WRONG;
                                mode_next   = MODE_OLD;
                            end
                        end
                        MODE_NEW:
                        begin
                            copy_en     = 1'b1;
                            status_next = ST_CHANGED;
                            mode_next   = MODE_IDLE;
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
            end
            else
            begin
                status_next = ST_IGNORED;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_IGNORED;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                stored_reg[i] <= default_digit(i);
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                status_reg <= status_next;
                if (copy_en)
                begin
                    for (int i = 0; i < CODE_LENGTH; i++)
                    begin
                        stored_reg[i] <= entry_reg[i];
                    end
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= kind;
            key_reg  <= key_code;
        end
        if (advance && wr_en)
        begin
            entry_reg[wr_idx] <= key_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entered_count = ECOUNT_W'(count_reg);
    assign lock_mode     = mode_reg;

    `KCL_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CODE_LENGTH),
                    "digit count beyond code length")
    `KCL_ASSERT_NOW(a_idle_empty, clk, rst_n, mode_reg == MODE_IDLE, count_reg == '0,
                    "idle with digits held")
    `KCL_ASSERT_NEXT(a_result_follows, clk, rst_n, advance, out_valid_reg,
                     "processed word produced no result")
    `KCL_ASSERT_NOW(a_no_stall_when_free, clk, rst_n, !out_valid_reg, !in_stall,
                    "input stalled with result register free")

endmodule
